[design/ugww_pkg.sv]
package ugww_pkg;

  localparam int unsigned POS_W   = 17;
  localparam int unsigned START_W = 16;
  localparam int unsigned WIDTH_W = 10;

  localparam logic [POS_W-1:0]   MAX_UNIT_BYTES = 17'd65536;
  localparam logic [START_W-1:0] MAX_START      = 16'd65535;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET    = 10'd80;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SP = 8'h20;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       verse_mode;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [START_W-1:0] line_start;
    logic [POS_W-1:0]   line_end;
    logic               line_is_verse;
    logic               last_line;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } push_t;

endpackage

[design/utf8_greedy_word_wrap.sv]
// Channel   Direction  Payload            Handshake
// in        input      ugww_pkg::item_t   in_valid / in_stall
// out       output     ugww_pkg::res_t    out_valid / out_stall
// cfg       input      line_width (10b)   cfg_we / cfg_wdata
//
// One byte per cycle unless stalled: each item is held in the input register,
// then the wrap logic updates its counters and queues zero, one or two lines.
// A four-entry result queue drains one line per cycle unless out_stall is
// high; the input register holds while fewer than two queue slots are free.
// Reset (rst, synchronous) clears the unit state and sets line_width to 80.
module utf8_greedy_word_wrap (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  ugww_pkg::item_t              in_item,
  output logic                         out_valid,
  input  logic                         out_stall,
  output ugww_pkg::res_t               out_item,
  input  logic                         cfg_we,
  input  logic [ugww_pkg::WIDTH_W-1:0] cfg_wdata
);

  ugww_pkg::item_t hold_item;
  logic            hold_valid;
  logic            room;
  logic            fire;
  ugww_pkg::push_t push;

  assign fire     = hold_valid && room;
  assign in_stall = hold_valid && !room;

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= (in_valid && !in_stall) || (hold_valid && !fire);
    end
  end

  ugww_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (hold_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .push      (push)
  );

  ugww_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (fire ? push : '0),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  a_empty_no_stall: assert property (@(posedge clk) disable iff (rst)
    !hold_valid |-> !in_stall)
    else $error("input stalled with empty input register");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    fire && push.count != 2'd0 |=> out_valid)
    else $error("queued line not presented");

  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    fire && hold_item.last_byte |-> push.count != 2'd0)
    else $error("unit end produced no line");
`endif

endmodule

[design/ugww_core.sv]
module ugww_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           fire,
  input  ugww_pkg::item_t                item,
  input  logic                           cfg_we,
  input  logic [ugww_pkg::WIDTH_W-1:0]   cfg_wdata,
  output ugww_pkg::push_t                push
);

  typedef struct packed {
    logic [ugww_pkg::POS_W-1:0]   byte_position;
    logic [ugww_pkg::START_W-1:0] line_start;
    logic [ugww_pkg::WIDTH_W-1:0] visual_count;
    logic [ugww_pkg::POS_W-1:0]   break_offset;
    logic [ugww_pkg::WIDTH_W-1:0] count_at_break;
    logic                         break_seen;
    logic                         full_pending;
    logic                         skip_linefeed;
    logic                         line_closed;
  } state_t;

  function automatic logic [ugww_pkg::POS_W-1:0] sat_end(
    input logic [ugww_pkg::POS_W:0] v
  );
    logic [ugww_pkg::POS_W:0] top;
    top = {1'b0, ugww_pkg::MAX_UNIT_BYTES};
    return (v > top) ? ugww_pkg::MAX_UNIT_BYTES : v[ugww_pkg::POS_W-1:0];
  endfunction

  function automatic logic [ugww_pkg::START_W-1:0] sat_start(
    input logic [ugww_pkg::POS_W-1:0] v
  );
    return (v > {1'b0, ugww_pkg::MAX_START}) ? ugww_pkg::MAX_START
                                             : v[ugww_pkg::START_W-1:0];
  endfunction

  state_t                       st;
  state_t                       st_next;
  logic [ugww_pkg::WIDTH_W-1:0] line_width;

  logic [7:0]                   b;
  logic                         v;
  logic                         lead;
  logic [ugww_pkg::WIDTH_W-1:0] w;
  logic [ugww_pkg::POS_W-1:0]   p;
  logic [ugww_pkg::POS_W-1:0]   p_inc;
  logic [ugww_pkg::POS_W-1:0]   brk_next;
  logic [ugww_pkg::POS_W-1:0]   next_start;
  logic [ugww_pkg::POS_W-1:0]   tail_next;
  logic [ugww_pkg::WIDTH_W-1:0] rem;
  logic                         early;
  logic                         pre_en;
  logic                         a_en;
  logic                         b_en;
  ugww_pkg::res_t               pre_res;
  ugww_pkg::res_t               a_res;
  ugww_pkg::res_t               b_res;

  always_comb begin
    b        = item.text_byte;
    v        = item.verse_mode;
    lead     = (b[7:6] != 2'b10);
    w        = (line_width == '0) ? ugww_pkg::WIDTH_W'(1) : line_width;
    p        = st.byte_position;
    p_inc    = sat_end({1'b0, p} + 1'b1);
    brk_next = v ? sat_end({1'b0, st.break_offset} + 1'b1) : st.break_offset;
    rem      = (st.visual_count >= st.count_at_break) ?
               st.visual_count - st.count_at_break : '0;
    st_next  = st;
    early    = 1'b0;
    pre_en   = 1'b0;
    a_en     = 1'b0;
    b_en     = 1'b0;
    pre_res  = '{line_start: st.line_start, line_end: st.break_offset,
                 line_is_verse: v, last_line: 1'b0};
    a_res    = pre_res;
    b_res    = pre_res;
    next_start = p;
    tail_next  = '0;

    if (st.line_closed) begin
      if (st.skip_linefeed && b == ugww_pkg::CH_LF) begin
        early                 = 1'b1;
        st_next.skip_linefeed = 1'b0;
        st_next.byte_position = p_inc;
        if (item.last_byte) begin
          pre_en            = 1'b1;
          pre_res.last_line = 1'b1;
          st_next           = '0;
        end
      end else begin
        pre_en  = 1'b1;
        st_next = '0;
        st_next.byte_position = p;
        st_next.line_start    = sat_start(p);
      end
    end else if (st.full_pending && lead) begin
      pre_en = 1'b1;
      if (st.break_seen) begin
        next_start = brk_next;
      end else begin
        pre_res.line_end = p;
        rem              = '0;
      end
      st_next = '0;
      st_next.byte_position = p;
      st_next.line_start    = sat_start(next_start);
      st_next.visual_count  = rem;
    end

    if (!early) begin
      if (v) begin
        if (b == ugww_pkg::CH_CR || b == ugww_pkg::CH_LF) begin
          st_next.break_offset  = p;
          st_next.line_closed   = 1'b1;
          st_next.skip_linefeed = (b == ugww_pkg::CH_CR);
        end else if (lead) begin
          st_next.visual_count = st_next.visual_count + 1'b1;
          if (b == ugww_pkg::CH_SP) begin
            st_next.break_offset   = p;
            st_next.count_at_break = st_next.visual_count;
            st_next.break_seen     = 1'b1;
          end
        end
      end else if (lead && b != ugww_pkg::CH_CR) begin
        st_next.visual_count = st_next.visual_count + 1'b1;
        if (b == ugww_pkg::CH_SP || b == ugww_pkg::CH_LF) begin
          st_next.break_offset   = p_inc;
          st_next.count_at_break = st_next.visual_count;
          st_next.break_seen     = 1'b1;
        end
      end
      if (!st_next.line_closed && st_next.visual_count >= w) begin
        st_next.full_pending = 1'b1;
      end
      st_next.byte_position = p_inc;

      a_res = '{line_start: st_next.line_start, line_end: st_next.break_offset,
                line_is_verse: v, last_line: 1'b1};
      tail_next = v ? sat_end({1'b0, st_next.break_offset} + 1'b1)
                    : st_next.break_offset;
      b_res = '{line_start: sat_start(tail_next), line_end: p_inc,
                line_is_verse: v, last_line: 1'b1};
      if (item.last_byte) begin
        a_en = 1'b1;
        if (st_next.line_closed) begin
          a_res.last_line = 1'b1;
        end else if (st_next.visual_count >= w && st_next.break_seen) begin
          if (tail_next < p_inc) begin
            a_res.last_line = 1'b0;
            b_en            = 1'b1;
          end
        end else begin
          a_res.line_end = p_inc;
        end
        st_next = '0;
      end
    end

    push.count  = 2'(pre_en) + 2'(a_en) + 2'(b_en);
    if (push.count == 2'd3) begin
      push.count = 2'd2;
    end
    push.first  = pre_en ? pre_res : a_res;
    push.second = (pre_en && a_en) ? a_res : b_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= '0;
      line_width <= ugww_pkg::WIDTH_RESET;
    end else begin
      if (fire) begin
        st <= st_next;
      end
      if (cfg_we) begin
        line_width <= cfg_wdata;
      end
    end
  end

endmodule

[design/ugww_outq.sv]
module ugww_outq (
  input  logic            clk,
  input  logic            rst,
  input  ugww_pkg::push_t push,
  output logic            room,
  output logic            out_valid,
  input  logic            out_stall,
  output ugww_pkg::res_t  out_item
);

  ugww_pkg::res_t mem [4];
  logic [1:0]     wr_ptr;
  logic [1:0]     rd_ptr;
  logic [2:0]     count;
  logic           pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign room      = (count <= 3'd2);
  assign out_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + 2'd1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push.count;
      rd_ptr <= rd_ptr + 2'(pop);
      count  <= count + 3'(push.count) - 3'(pop);
    end
  end

endmodule
